FILE: design/rpc_pkg.sv
// ----------------------------------------------------------------------------
// rpc_pkg: shared types and constants for the pair-count run-length encoder
// Holds the queued request format between front and back, queue sizing and
// the encoder's fixed thresholds.
// ----------------------------------------------------------------------------
package rpc_pkg;

  // Width of the bytes-left field of an input request.
  localparam int LEN_BITS    = 16;

  // Encoder thresholds.
  localparam logic [7:0] FULL_COUNT = 8'd255;
  localparam int NEAR_END    = 3;
  localparam int SHORT_MIN   = 2;

  // Results one input request may cause.
  localparam int MAX_RESULTS = 3;
  localparam int NUM_W       = $clog2(MAX_RESULTS + 1);
  localparam int IDX_W       = $clog2(MAX_RESULTS);

  // Request queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // One classified input request: up to three result bytes.
  typedef struct packed {
    logic [NUM_W-1:0]             num;     // results to emit, 1..MAX_RESULTS
    logic [MAX_RESULTS-1:0][7:0]  bytes;   // result bytes, index 0 first
    logic                         err;     // short-block error result
  } cmd_t;

  // Queue status seen by the back and the top level.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

FILE: design/rpc_front.sv
// ----------------------------------------------------------------------------
// rpc_front: input stage of the pair-count run-length encoder
// Tracks block and run state and turns each accepted request into a command
// of up to three result bytes for the queue.
// ----------------------------------------------------------------------------
module rpc_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic [7:0]                  data_byte,
  input  logic [rpc_pkg::LEN_BITS-1:0] bytes_left,
  output logic                        push,
  output rpc_pkg::cmd_t               cmd
);
  import rpc_pkg::*;

  logic [7:0] prev_r, prev_nxt;
  logic       run_r, run_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic       started_r, started_nxt;
  logic       rej_r, rej_nxt;

  logic [7:0] p;
  logic       run_now;
  logic [7:0] cnt_now;
  logic [7:0] inc;
  logic       near_end;
  logic       at_end;

  always_comb begin
    p        = started_r ? prev_r : 8'd0;
    run_now  = started_r ? run_r : 1'b0;
    cnt_now  = started_r ? cnt_r : 8'd0;
    inc      = cnt_now + 8'd1;
    near_end = bytes_left < LEN_BITS'(NEAR_END);
    at_end   = bytes_left == '0;

    prev_nxt    = prev_r;
    run_nxt     = run_r;
    cnt_nxt     = cnt_r;
    started_nxt = started_r;
    rej_nxt     = rej_r;
    cmd         = '0;

    if (!started_r && bytes_left < LEN_BITS'(SHORT_MIN)) begin
      // Short block: one error result, swallow the rest.
      prev_nxt    = 8'd0;
      run_nxt     = 1'b0;
      cnt_nxt     = 8'd0;
      started_nxt = !at_end;
      rej_nxt     = !at_end;
      cmd.num     = NUM_W'(1);
      cmd.err     = 1'b1;
    end else if (started_r && rej_r) begin
      if (at_end) begin
        started_nxt = 1'b0;
        rej_nxt     = 1'b0;
      end
    end else begin
      prev_nxt    = p;
      run_nxt     = run_now;
      cnt_nxt     = cnt_now;
      rej_nxt     = 1'b0;
      started_nxt = 1'b1;
      if (run_now) begin
        if (data_byte == p) begin
          cnt_nxt = inc;
          if (inc == FULL_COUNT) begin
            cmd.num      = NUM_W'(1);
            cmd.bytes[0] = inc;
            run_nxt      = 1'b0;
          end else if (near_end) begin
            cmd.num      = NUM_W'(2);
            cmd.bytes[0] = inc;
            cmd.bytes[1] = data_byte;
            run_nxt      = 1'b0;
          end
        end else begin
          // Run broken: count, then the new literal.
          cmd.num      = NUM_W'(2);
          cmd.bytes[0] = cnt_now;
          cmd.bytes[1] = data_byte;
          run_nxt      = 1'b0;
          prev_nxt     = data_byte;
        end
      end else begin
        cmd.num      = NUM_W'(1);
        cmd.bytes[0] = data_byte;
        if (!at_end) begin
          if (data_byte == p) begin
            if (near_end) begin
              cmd.num      = NUM_W'(3);
              cmd.bytes[1] = 8'd0;
              cmd.bytes[2] = data_byte;
            end else begin
              run_nxt = 1'b1;
              cnt_nxt = 8'd0;
            end
          end
          prev_nxt = data_byte;
        end
      end
      if (at_end) begin
        started_nxt = 1'b0;
        run_nxt     = 1'b0;
      end
    end
    push = accept && (cmd.num != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r    <= 8'd0;
      run_r     <= 1'b0;
      cnt_r     <= 8'd0;
      started_r <= 1'b0;
      rej_r     <= 1'b0;
    end else if (accept) begin
      prev_r    <= prev_nxt;
      run_r     <= run_nxt;
      cnt_r     <= cnt_nxt;
      started_r <= started_nxt;
      rej_r     <= rej_nxt;
    end
  end

endmodule

FILE: design/rpc_queue.sv
// ----------------------------------------------------------------------------
// rpc_queue: command queue between front and back
// Small flip-flop FIFO so that input and output stall independently.
// ----------------------------------------------------------------------------
module rpc_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  rpc_pkg::cmd_t   push_cmd,
  input  logic            pop,
  output rpc_pkg::cmd_t   head,
  output rpc_pkg::q_stat_t stat
);
  import rpc_pkg::*;

  cmd_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   count_r;

  assign head       = mem_r[rd_ptr_r];
  assign stat.full  = count_r == (QPTR_W+1)'(QUEUE_DEPTH);
  assign stat.empty = count_r == '0;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

FILE: design/rpc_back.sv
// ----------------------------------------------------------------------------
// rpc_back: output stage of the pair-count run-length encoder
// Unpacks queued commands into single result requests, one per cycle while
// out_stall is low, into an output register.
// ----------------------------------------------------------------------------
module rpc_back (
  input  logic             clk,
  input  logic             rst_n,
  input  rpc_pkg::cmd_t    head,
  input  rpc_pkg::q_stat_t stat,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_byte,
  output logic             out_last_of_item,
  output logic             out_too_short
);
  import rpc_pkg::*;

  cmd_t             cmd_r;
  logic             have_r, have_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             valid_r, valid_nxt;
  logic [7:0]       byte_r;
  logic             last_r;
  logic             short_r;

  cmd_t             src;
  logic [IDX_W-1:0] idx;
  logic             src_valid;
  logic             load;
  logic             is_last;

  always_comb begin
    src       = have_r ? cmd_r : head;
    idx       = have_r ? idx_r : '0;
    src_valid = have_r || !stat.empty;
    load      = src_valid && (!valid_r || !out_stall);
    is_last   = NUM_W'(idx) == src.num - NUM_W'(1);
    pop       = load && !have_r;
    have_nxt  = have_r;
    idx_nxt   = idx_r;
    if (load) begin
      have_nxt = !is_last;
      idx_nxt  = idx + IDX_W'(1);
    end
    valid_nxt = load || (valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r  <= 1'b0;
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      have_r  <= have_nxt;
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_r <= head;
    end
    if (load) begin
      byte_r  <= src.bytes[idx];
      last_r  <= is_last;
      short_r <= src.err;
    end
  end

  assign out_valid        = valid_r;
  assign out_byte         = byte_r;
  assign out_last_of_item = last_r;
  assign out_too_short    = short_r;

endmodule

FILE: design/rle_pair_count_encoder.sv
// ----------------------------------------------------------------------------
// rle_pair_count_encoder: byte-stream run-length encoder with pair counts
// Path: the edge that accepts a request writes its command into the queue;
//   the back then loads its results into the output register in queue
//   order, once that register is free.
// Throughput: one input request per cycle while the queue has room; the
//   single output register emits one result per cycle while out_stall is
//   low, so the results of a request with two or three results leave in turn.
// Reset: synchronous, active low; clears block/run state, queue and output.
// ----------------------------------------------------------------------------
module rle_pair_count_encoder (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   in_data_byte,
  input  logic [rpc_pkg::LEN_BITS-1:0] in_bytes_left,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   out_byte,
  output logic                         out_last_of_item,
  output logic                         out_too_short
);
  import rpc_pkg::*;

  logic    accept;
  logic    push;
  logic    pop;
  cmd_t    push_cmd;
  cmd_t    head;
  q_stat_t stat;

  // Stall the input only when the queue has no room for another command.
  assign in_stall = stat.full;
  assign accept   = in_valid && !in_stall;

  // Front: classify each request and update block/run state.
  rpc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .data_byte  (in_data_byte),
    .bytes_left (in_bytes_left),
    .push       (push),
    .cmd        (push_cmd)
  );

  // Queue: decouple input stalls from output stalls.
  rpc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .stat     (stat)
  );

  // Back: serialize each command into result requests.
  rpc_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .stat             (stat),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_last_of_item (out_last_of_item),
    .out_too_short    (out_too_short)
  );

`ifndef SYNTH
  // Never write a full queue.
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !stat.full) else $error("push into full queue");

  // Never pop an empty queue.
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty) else $error("pop from empty queue");

  // A short-block error is always a request's only result.
  a_err_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_too_short) |-> out_last_of_item)
    else $error("error result not last of its request");
`endif

endmodule

FILE: tb/sv/rle_pair_count_encoder_checker.sv
// ----------------------------------------------------------------------------
// rle_pair_count_encoder_checker: result predictor and scoreboard
// Watches the request and result channels of the pair-count run-length
// encoder, computes the expected result bytes of every accepted request and
// compares each accepted result against the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module rle_pair_count_encoder_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [7:0]                   in_data_byte,
  input  logic [rpc_pkg::LEN_BITS-1:0] in_bytes_left,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [7:0]                   out_byte,
  input  logic                         out_last_of_item,
  input  logic                         out_too_short,
  output int                           mismatches,
  output int                           pending_results,
  output int                           results_checked,
  output int                           short_results
);

  localparam int PRINT_CAP = 100;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
    logic       short_blk;
  } enc_result_t;

  enc_result_t expected_q[$];

  // Encoder state as the block should hold it.
  logic [7:0] prev_byte;
  logic       run_on;
  logic [7:0] rep_count;
  logic       blk_open;
  logic       dropping;

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_CAP)
      $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Compute the results of one accepted request and queue them.
  task automatic predict_request(input logic [7:0] c,
                                 input logic [rpc_pkg::LEN_BITS-1:0] left);
    enc_result_t batch[$];
    logic        handled;
    handled = 1'b0;
    if (!blk_open) begin
      prev_byte = 8'h00;
      run_on    = 1'b0;
      rep_count = 8'h00;
      dropping  = 1'b0;
      if (left < rpc_pkg::SHORT_MIN) begin
        batch.push_back('{value: 8'h00, last: 1'b0, short_blk: 1'b1});
        if (left != 0) begin
          blk_open = 1'b1;
          dropping = 1'b1;
        end
        handled = 1'b1;
      end else begin
        blk_open = 1'b1;
      end
    end else if (dropping) begin
      if (left == 0) begin
        blk_open = 1'b0;
        dropping = 1'b0;
      end
      handled = 1'b1;
    end

    if (!handled) begin
      if (run_on) begin
        if (c == prev_byte) begin
          rep_count = rep_count + 8'd1;
          if (rep_count == rpc_pkg::FULL_COUNT) begin
            batch.push_back('{value: rep_count, last: 1'b0, short_blk: 1'b0});
            run_on = 1'b0;
          end else if (left < rpc_pkg::NEAR_END) begin
            batch.push_back('{value: rep_count, last: 1'b0, short_blk: 1'b0});
            batch.push_back('{value: c, last: 1'b0, short_blk: 1'b0});
            run_on = 1'b0;
          end
        end else begin
          batch.push_back('{value: rep_count, last: 1'b0, short_blk: 1'b0});
          batch.push_back('{value: c, last: 1'b0, short_blk: 1'b0});
          run_on    = 1'b0;
          prev_byte = c;
        end
      end else begin
        batch.push_back('{value: c, last: 1'b0, short_blk: 1'b0});
        if (left != 0) begin
          if (c == prev_byte) begin
            if (left < rpc_pkg::NEAR_END) begin
              batch.push_back('{value: 8'h00, last: 1'b0, short_blk: 1'b0});
              batch.push_back('{value: c, last: 1'b0, short_blk: 1'b0});
            end else begin
              run_on    = 1'b1;
              rep_count = 8'h00;
            end
          end
          prev_byte = c;
        end
      end
      if (left == 0) begin
        blk_open = 1'b0;
        run_on   = 1'b0;
      end
    end

    if (batch.size() > 0)
      batch[batch.size()-1].last = 1'b1;
    foreach (batch[i])
      expected_q.push_back(batch[i]);
  endtask

  always @(posedge clk) begin
    enc_result_t exp_res;
    if (!rst_n) begin
      expected_q.delete();
      prev_byte       = 8'h00;
      run_on          = 1'b0;
      rep_count       = 8'h00;
      blk_open        = 1'b0;
      dropping        = 1'b0;
      mismatches      = 0;
      results_checked = 0;
      short_results   = 0;
    end else begin
      // Check results before queuing this edge's request; a request never
      // produces a result on the edge that accepts it.
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result byte=%02h last=%0b short=%0b",
                                    out_byte, out_last_of_item, out_too_short));
        end else begin
          exp_res = expected_q.pop_front();
          results_checked++;
          if (exp_res.short_blk)
            short_results++;
          if (out_too_short !== exp_res.short_blk)
            report_mismatch($sformatf("too_short %0b, expected %0b",
                                      out_too_short, exp_res.short_blk));
          // The byte of a short-block error carries no meaning.
          if (!exp_res.short_blk && out_byte !== exp_res.value)
            report_mismatch($sformatf("out_byte %02h, expected %02h",
                                      out_byte, exp_res.value));
          if (out_last_of_item !== exp_res.last)
            report_mismatch($sformatf("last_of_item %0b, expected %0b",
                                      out_last_of_item, exp_res.last));
        end
      end
      if (in_valid && !in_stall)
        predict_request(in_data_byte, in_bytes_left);
    end
    pending_results = expected_q.size();
  end

endmodule

FILE: tb/sv/rle_pair_count_encoder_test.sv
// ----------------------------------------------------------------------------
// rle_pair_count_encoder_test: stimulus and verdict for the run-length encoder
// Drives byte requests grouped into blocks (directed corner blocks, then
// random well-formed, short and malformed blocks, one with a saturating run)
// under random sender gaps and receiver stalls. A checker beside the block
// predicts and compares every result.
// ----------------------------------------------------------------------------
module rle_pair_count_encoder_test;

  localparam int RANDOM_ITEMS = 330;
  localparam int DRAIN_CYCLES = 64;
  localparam int HOLD_CYCLES  = 120;
  localparam int HOLD_AT      = 250;

  logic                         clk           = 1'b0;
  logic                         rst_n         = 1'b0;
  logic                         in_valid      = 1'b0;
  logic [7:0]                   in_data_byte  = 8'h00;
  logic [rpc_pkg::LEN_BITS-1:0] in_bytes_left = '0;
  logic                         out_stall     = 1'b0;
  logic                         in_stall;
  logic                         out_valid;
  logic [7:0]                   out_byte;
  logic                         out_last_of_item;
  logic                         out_too_short;

  int mismatches;
  int pending_results;
  int results_checked;
  int short_results;

  int requests_sent  = 0;
  int blocks_sent    = 0;
  int no_gap_left    = 0;

  rle_pair_count_encoder dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_bytes_left    (in_bytes_left),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_last_of_item (out_last_of_item),
    .out_too_short    (out_too_short)
  );

  rle_pair_count_encoder_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_bytes_left    (in_bytes_left),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_last_of_item (out_last_of_item),
    .out_too_short    (out_too_short),
    .mismatches       (mismatches),
    .pending_results  (pending_results),
    .results_checked  (results_checked),
    .short_results    (short_results)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Pick the idle gap after a request: mostly none or short, a few long,
  // and now and then a gap-free burst.
  function automatic int next_gap();
    int r;
    if (no_gap_left > 0) begin
      no_gap_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      no_gap_left = $urandom_range(15, 40);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // Offer one request, hold it until accepted, then idle for a random gap.
  // Drop valid only when a gap follows, so back-to-back requests keep it high.
  task automatic send_request(input logic [7:0] d,
                              input logic [rpc_pkg::LEN_BITS-1:0] left);
    int gap;
    in_data_byte  <= d;
    in_bytes_left <= left;
    in_valid      <= 1'b1;
    do @(posedge clk); while (in_stall);
    requests_sent++;
    gap = next_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Pick a fresh byte, biased toward zero, all-ones and alternating patterns.
  function automatic logic [7:0] fresh_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return 8'h00;
    if (r < 30) return 8'hFF;
    if (r < 35) return 8'h55;
    if (r < 40) return 8'hAA;
    return 8'($urandom_range(0, 255));
  endfunction

  // Send a well-formed block of len bytes with a countdown in bytes_left;
  // repeat_pct sets how often a byte repeats the one before it.
  task automatic send_block(input int len, input int repeat_pct);
    logic [7:0] d;
    d = 8'h00;
    for (int i = 0; i < len; i++) begin
      if (i == 0 || $urandom_range(0, 99) >= repeat_pct)
        d = fresh_byte();
      send_request(d, rpc_pkg::LEN_BITS'(len - 1 - i));
    end
    blocks_sent++;
  endtask

  // Receiver: random stall pattern, with one long hold-off so the block
  // backs up and stalls its input while requests keep coming.
  initial begin
    int cyc;
    int n;
    int r;
    bit held;
    logic v;
    cyc  = 0;
    held = 1'b0;
    forever begin
      if (!held && cyc >= HOLD_AT) begin
        v    = 1'b1;
        n    = HOLD_CYCLES;
        held = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          v = 1'b0; n = $urandom_range(1, 6);
        end else if (r < 75) begin
          v = 1'b1; n = $urandom_range(1, 3);
        end else if (r < 85) begin
          v = 1'b0; n = $urandom_range(25, 60);
        end else if (r < 95) begin
          v = 1'b1; n = $urandom_range(4, 10);
        end else begin
          v = 1'b1; n = $urandom_range(15, 30);
        end
      end
      out_stall <= v;
      repeat (n) @(posedge clk);
      cyc += n;
    end
  end

  // Stimulus and verdict.
  initial begin
    int r;
    int len;
    int run_len;
    int pre;
    int post;
    logic [7:0] d;
    logic [7:0] run_byte;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Short block of one byte: single error result.
    send_request(8'hFF, 16'd0);
    blocks_sent++;
    // Short block of two bytes: error on the first, the second is dropped.
    send_request(8'h12, 16'd1);
    send_request(8'h34, 16'd0);
    blocks_sent++;
    // Short block followed by junk lengths, swallowed up to the block end.
    send_request(8'hAA, 16'd1);
    send_request(8'h55, 16'hFFFF);
    send_request(8'h00, 16'd0);
    blocks_sent++;
    // Zero first byte pairs with the cleared previous byte; the run is broken,
    // then pairs are found close to the end, and the last byte is plain.
    send_request(8'h00, 16'd5);
    send_request(8'h00, 16'd4);
    send_request(8'hC3, 16'd3);
    send_request(8'hC3, 16'd2);
    send_request(8'hC3, 16'd1);
    send_request(8'hC3, 16'd0);
    blocks_sent++;
    // Run that ends because the block end is near, then a late pair.
    send_request(8'h5A, 16'd4);
    send_request(8'h5A, 16'd3);
    send_request(8'h5A, 16'd2);
    send_request(8'h5A, 16'd1);
    send_request(8'h00, 16'd0);
    blocks_sent++;
    // Largest lengths, a run, and a break on the last byte.
    send_request(8'h81, 16'hFFFF);
    send_request(8'h81, 16'h8000);
    send_request(8'h81, 16'h7FFF);
    send_request(8'h42, 16'd0);
    blocks_sent++;

    // Random blocks; the saturating-run block rides on top of the item count.
    for (int blk = 0; requests_sent < 21 + RANDOM_ITEMS || blk <= 4; blk++) begin
      if (blk == 4) begin
        // A run long enough to reach the full count, with bytes around it.
        pre      = $urandom_range(1, 4);
        run_len  = $urandom_range(257, 262);
        post     = $urandom_range(1, 5);
        len      = pre + run_len + post;
        run_byte = 8'($urandom_range(0, 255));
        for (int i = 0; i < len; i++) begin
          if (i >= pre && i < pre + run_len)
            d = run_byte;
          else
            d = 8'($urandom_range(0, 255));
          send_request(d, rpc_pkg::LEN_BITS'(len - 1 - i));
        end
        blocks_sent++;
        continue;
      end
      r = $urandom_range(0, 99);
      if (r < 60) begin
        if ($urandom_range(0, 99) < 15)
          len = $urandom_range(17, 40);
        else
          len = $urandom_range(3, 16);
        send_block(len, $urandom_range(20, 70));
      end else if (r < 70) begin
        send_block($urandom_range(1, 2), 50);
      end else if (r < 78) begin
        // Short start, then junk lengths until a zero closes the block.
        send_request(fresh_byte(), 16'd1);
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++)
          send_request(fresh_byte(), 16'($urandom_range(1, 65535)));
        send_request(fresh_byte(), 16'd0);
        blocks_sent++;
      end else begin
        // Lengths that do not count down: use each as given.
        len = $urandom_range(2, 10);
        d   = fresh_byte();
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 99) < 50)
            d = fresh_byte();
          if (i == len - 1)
            send_request(d, 16'd0);
          else if ($urandom_range(0, 99) < 50)
            send_request(d, 16'($urandom_range(1, 65535)));
          else
            send_request(d, 16'($urandom_range(1, 4)));
        end
        blocks_sent++;
      end
    end

    in_valid <= 1'b0;
    // Sample at the falling edge, clear of the checker's updates.
    do @(negedge clk); while (pending_results != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d requests in %0d blocks, including a full-count run",
             requests_sent, blocks_sent);
    $display("checked %0d results, %0d of them short-block errors",
             results_checked, short_results);
    if (mismatches == 0) begin
      $display("rle_pair_count_encoder_test: clean");
    end else begin
      $display("rle_pair_count_encoder_test: errors");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", pending_results);
    $display("rle_pair_count_encoder_test: errors");
    $finish;
  end

endmodule

FILE: sim.f
design/rpc_pkg.sv
design/rpc_front.sv
design/rpc_queue.sv
design/rpc_back.sv
design/rle_pair_count_encoder.sv
tb/sv/rle_pair_count_encoder_checker.sv
tb/sv/rle_pair_count_encoder_test.sv
